### src/limit_order_book_matcher_assert.svh
// assertion macros shared by the order book rtl
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LOBM_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("order book check failed");

// next-cycle implication, checked outside reset
`define LOBM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("order book check failed");

`endif

### src/lobm_pkg.sv
// shared types and codes of the order book matcher
`timescale 1ns / 1ps
`default_nettype none

package lobm_pkg;

   localparam int MAX_RESULTS   = 64;
   localparam int FILL_CNT_BITS = 7;

   typedef enum logic [1:0] {
      FUNC_MATCH  = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_CANCEL = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      KIND_FILL        = 3'd0,
      KIND_ADD_OK      = 3'd1,
      KIND_ADD_FULL    = 3'd2,
      KIND_CANCELLED   = 3'd3,
      KIND_CANCEL_MISS = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] resting_left;
      logic [31:0] resting_id;
      logic [31:0] aggressor_left;
      logic [31:0] aggressor_id;
      logic [31:0] fill_price;
      logic [31:0] fill_quantity;
   } result_type;

endpackage

`default_nettype wire

### src/lobm_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lobm_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### src/limit_order_book_matcher.sv
// Two-sided price-time priority order book with matching, add and cancel.
//
// Requests arrive as beats on req_*: tuser holds the function (match, add,
// cancel) and the side, tdata holds price, quantity and order id. Every add
// or cancel gives one response beat on rsp_*; a match gives one beat per
// fill, the final one flagged by tlast, and none if nothing crosses.
// The book lives in one ram of 2*ORDERS_PER_SIDE entries; valid bits sit in
// flops. A cancel sweeps its side, one entry read a cycle. Each fill of a
// match sweeps the opposite side for the best entry through the single ram
// read port and then reads and writes it back. One request is worked on at a
// time; req_tready is high only when the block is free. Responses wait in an
// output register, so a stall on rsp_tready holds the sweep only when a new
// beat is ready to go.
// Reset empties both sides and clears the arrival counter; ram contents are
// left as they are since nothing unwritten is ever read as valid.
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_book_matcher_assert.svh"

module limit_order_book_matcher #(
   parameter int ORDERS_PER_SIDE = 64,
   parameter int PRICE_BITS      = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // price, quantity, order_id
   input  wire logic [95:0]  req_tdata,
   // func, side
   input  wire logic [2:0]   req_tuser,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // fill_quantity, fill_price, aggressor_id, aggressor_left, resting_id, resting_left
   output      logic [191:0] rsp_tdata,
   // result_kind
   output      logic [2:0]   rsp_tuser,
   output      logic         rsp_tlast
);

   localparam int ENTRIES = 2 * ORDERS_PER_SIDE;
   localparam int AW      = $clog2(ENTRIES);
   localparam int SW      = (ORDERS_PER_SIDE > 1) ? $clog2(ORDERS_PER_SIDE) : 1;
   localparam int CW      = $clog2(ORDERS_PER_SIDE + 1);
   localparam int PW      = PRICE_BITS;
   localparam int DW      = PW + 80;
   localparam int FB      = lobm_pkg::FILL_CNT_BITS;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_MT_SCAN  = 6'b000010,
      ST_MT_READ  = 6'b000100,
      ST_MT_UPD   = 6'b001000,
      ST_CAN_SCAN = 6'b010000,
      ST_OUT      = 6'b100000
   } state_type;

   state_type            state_ff, state_in, after_ff, after_in;
   logic                 side_ff, side_in;
   logic [PW-1:0]        lim_ff, lim_in;
   logic [31:0]          id_ff, id_in;
   logic [31:0]          left_ff, left_in;
   logic [FB-1:0]        fills_ff, fills_in;
   logic [15:0]          arrival_ff, arrival_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [SW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 best_vld_ff, best_vld_in;
   logic [SW-1:0]        best_idx_ff, best_idx_in;
   logic [PW-1:0]        best_p_ff, best_p_in;
   logic [15:0]          best_dist_ff, best_dist_in;
   logic                 found_ff, found_in;
   logic                 pend_ff, pend_in;
   lobm_pkg::result_type res_ff, res_in;
   logic                 res_last_ff, res_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lobm_pkg::result_type rsp_res_ff, rsp_res_in;
   logic                 rsp_last_ff, rsp_last_in;

   // request fields
   lobm_pkg::func_type in_func;
   logic               in_side;
   logic [31:0]        in_price, in_qty, in_id;
   logic [63:0]        in_price_ext;
   logic [PW-1:0]      in_price_m;
   logic [127:0]       in_pm_ext;
   logic               req_fire;

   assign in_func      = lobm_pkg::func_type'(req_tuser[1:0]);
   assign in_side      = req_tuser[2];
   assign in_price     = req_tdata[31:0];
   assign in_qty       = req_tdata[63:32];
   assign in_id        = req_tdata[95:64];
   assign in_price_ext = 64'(in_price);
   assign in_price_m   = in_price_ext[PW-1:0];
   assign in_pm_ext    = 128'(in_price_m);
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;

   // lowest free slot on the request side
   logic [ORDERS_PER_SIDE-1:0] side_valid;
   logic                       free_found;
   logic [SW-1:0]              free_slot;

   assign side_valid = in_side ? valid_ff[ENTRIES-1:ORDERS_PER_SIDE]
                               : valid_ff[ORDERS_PER_SIDE-1:0];

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int s = ORDERS_PER_SIDE - 1; s >= 0; s--) begin
         if (!side_valid[s]) begin
            free_found = 1'b1;
            free_slot  = SW'(s);
         end
      end
   end

   // ram and entry addressing
   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [DW-1:0]   wr_data, rd_data;
   logic [AW-1:0]   book_base, req_base, cmp_addr, best_addr;

   assign book_base = side_ff ? AW'(ORDERS_PER_SIDE) : '0;
   assign req_base  = in_side ? AW'(ORDERS_PER_SIDE) : '0;
   assign cmp_addr  = book_base + AW'(cmp_idx_ff);
   assign best_addr = book_base + AW'(best_idx_ff);
   assign rd_addr   = (state_ff == ST_MT_READ) ? best_addr
                                               : book_base + AW'(rd_idx_ff[SW-1:0]);

   lobm_ram #(
      .WIDTH(DW),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // entry fields as read: price, id, qty, age from the top down
   logic [PW-1:0]  rp;
   logic [31:0]    rid, rqty;
   logic [15:0]    rage, rdist;
   logic [127:0]   rp_ext;
   logic           cv, crosses, better_p, take_this, cancel_hit;
   logic           issuing, scan_done;

   assign rp      = rd_data[DW-1:80];
   assign rid     = rd_data[79:48];
   assign rqty    = rd_data[47:16];
   assign rage    = rd_data[15:0];
   assign rp_ext  = 128'(rp);
   assign rdist   = arrival_ff - rage;
   assign cv      = cmp_vld_ff && valid_ff[cmp_addr];
   // scanned side is the sell book for a buy aggressor
   assign crosses  = side_ff ? (rp <= lim_ff) : (rp >= lim_ff);
   assign better_p = side_ff ? (rp < best_p_ff) : (rp > best_p_ff);
   assign take_this = cv && crosses &&
                      (!best_vld_ff || better_p || (rp == best_p_ff && rdist > best_dist_ff));
   assign cancel_hit = cv && (rid == id_ff) && (rp == lim_ff);
   assign issuing    = (rd_idx_ff < CW'(ORDERS_PER_SIDE));
   assign scan_done  = !issuing && !cmp_vld_ff;

   // fill arithmetic
   logic [31:0] take, new_q, new_left;

   assign take     = (left_ff < rqty) ? left_ff : rqty;
   assign new_q    = rqty - take;
   assign new_left = left_ff - take;

   always_comb begin
      state_in     = state_ff;
      after_in     = after_ff;
      side_in      = side_ff;
      lim_in       = lim_ff;
      id_in        = id_ff;
      left_in      = left_ff;
      fills_in     = fills_ff;
      arrival_in   = arrival_ff;
      valid_in     = valid_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_p_in    = best_p_ff;
      best_dist_in = best_dist_ff;
      found_in     = found_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in   = rsp_res_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = req_base + AW'(free_slot);
      wr_data      = {in_price_m, in_id, in_qty, arrival_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               side_in     = in_side;
               lim_in      = in_price_m;
               id_in       = in_id;
               left_in     = in_qty;
               fills_in    = '0;
               pend_in     = 1'b0;
               rd_idx_in   = '0;
               best_vld_in = 1'b0;
               found_in    = 1'b0;
               after_in    = ST_IDLE;
               res_last_in = 1'b1;
               res_in      = '{kind: lobm_pkg::KIND_ADD_FULL, resting_left: 32'd0,
                               resting_id: in_id, aggressor_left: 32'd0,
                               aggressor_id: 32'd0, fill_price: in_pm_ext[31:0],
                               fill_quantity: 32'd0};
               unique case (in_func)
                  lobm_pkg::FUNC_MATCH: begin
                     side_in = !in_side;
                     if (in_qty != 32'd0) begin
                        state_in = ST_MT_SCAN;
                     end
                  end
                  lobm_pkg::FUNC_ADD: begin
                     state_in = ST_OUT;
                     if (free_found) begin
                        wr_en                                = 1'b1;
                        valid_in[req_base + AW'(free_slot)] = 1'b1;
                        arrival_in                           = arrival_ff + 16'd1;
                        res_in.kind                          = lobm_pkg::KIND_ADD_OK;
                        res_in.resting_left                  = in_qty;
                     end
                  end
                  lobm_pkg::FUNC_CANCEL: begin
                     state_in = ST_CAN_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_MT_SCAN: begin
            if (issuing) begin
               rd_idx_in  = rd_idx_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[SW-1:0];
            end
            if (take_this) begin
               best_vld_in  = 1'b1;
               best_idx_in  = cmp_idx_ff;
               best_p_in    = rp;
               best_dist_in = rdist;
            end
            if (scan_done) begin
               // the held fill goes out once we know whether another follows
               if (best_vld_ff) begin
                  if (pend_ff) begin
                     res_last_in = 1'b0;
                     after_in    = ST_MT_READ;
                     state_in    = ST_OUT;
                  end else begin
                     state_in = ST_MT_READ;
                  end
               end else if (pend_ff) begin
                  res_last_in = 1'b1;
                  after_in    = ST_IDLE;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_IDLE;
               end
               pend_in = 1'b0;
            end
         end

         ST_MT_READ: begin
            state_in = ST_MT_UPD;
         end

         ST_MT_UPD: begin
            wr_en    = 1'b1;
            wr_addr  = best_addr;
            wr_data  = {rp, rid, new_q, rage};
            if (new_q == 32'd0) begin
               valid_in[best_addr] = 1'b0;
            end
            left_in  = new_left;
            fills_in = fills_ff + FB'(1);
            res_in   = '{kind: lobm_pkg::KIND_FILL, resting_left: new_q, resting_id: rid,
                        aggressor_left: new_left, aggressor_id: id_ff,
                        fill_price: rp_ext[31:0], fill_quantity: take};
            if (new_left == 32'd0 || fills_ff == FB'(lobm_pkg::MAX_RESULTS - 1)) begin
               res_last_in = 1'b1;
               after_in    = ST_IDLE;
               state_in    = ST_OUT;
            end else begin
               pend_in     = 1'b1;
               rd_idx_in   = '0;
               best_vld_in = 1'b0;
               state_in    = ST_MT_SCAN;
            end
         end

         ST_CAN_SCAN: begin
            if (issuing) begin
               rd_idx_in  = rd_idx_ff + CW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[SW-1:0];
            end
            if (cancel_hit) begin
               valid_in[cmp_addr] = 1'b0;
               found_in           = 1'b1;
            end
            if (scan_done) begin
               res_in.kind = found_ff ? lobm_pkg::KIND_CANCELLED
                                      : lobm_pkg::KIND_CANCEL_MISS;
               state_in    = ST_OUT;
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_last_in  = res_last_ff;
               state_in     = after_ff;
               if (after_ff == ST_MT_READ) begin
                  best_vld_in = best_vld_ff;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         valid_ff     <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         fills_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         valid_ff     <= valid_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_ff      <= pend_in;
         fills_ff     <= fills_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff      <= side_in;
      lim_ff       <= lim_in;
      id_ff        <= id_in;
      left_ff      <= left_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_vld_ff  <= best_vld_in;
      best_idx_ff  <= best_idx_in;
      best_p_ff    <= best_p_in;
      best_dist_ff <= best_dist_in;
      found_ff     <= found_in;
      res_ff       <= res_in;
      res_last_ff  <= res_last_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_res_ff.resting_left, rsp_res_ff.resting_id,
                        rsp_res_ff.aggressor_left, rsp_res_ff.aggressor_id,
                        rsp_res_ff.fill_price, rsp_res_ff.fill_quantity};
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_last_ff;

   `LOBM_ASSERT_NOW(a_upd_entry_live, state_ff == ST_MT_UPD, valid_ff[best_addr])
   `LOBM_ASSERT_NOW(a_fill_bound, state_ff == ST_MT_UPD,
      fills_ff < FB'(lobm_pkg::MAX_RESULTS))
   `LOBM_ASSERT_NOW(a_filled_is_last,
      rsp_tvalid && rsp_tuser == lobm_pkg::KIND_FILL && rsp_tdata[127:96] == 32'd0,
      rsp_tlast)
   `LOBM_ASSERT_NEXT(a_add_stamps,
      req_fire && in_func == lobm_pkg::FUNC_ADD && free_found,
      arrival_ff == $past(arrival_ff) + 16'd1)

endmodule

`default_nettype wire
